>>> src/vute_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vute_pkg
// Shared constants of the vector unit transfer execute block.
// ----------------------------------------------------------------------------
package vute_pkg;

  localparam int MEM_QWORDS_DEF = 1024;
  localparam int LANE_W         = 32;
  localparam int LANES          = 4;
  localparam int QWORD_W        = LANE_W * LANES;
  localparam int VREGS          = 32;
  localparam int VREG_AW        = 5;

  localparam logic [3:0] CMD_MOVE = 4'd0;
  localparam logic [3:0] CMD_MFIR = 4'd1;
  localparam logic [3:0] CMD_MTIR = 4'd2;
  localparam logic [3:0] CMD_MR32 = 4'd3;
  localparam logic [3:0] CMD_LQ   = 4'd4;
  localparam logic [3:0] CMD_LQD  = 4'd5;
  localparam logic [3:0] CMD_LQI  = 4'd6;
  localparam logic [3:0] CMD_SQ   = 4'd7;
  localparam logic [3:0] CMD_SQD  = 4'd8;
  localparam logic [3:0] CMD_SQI  = 4'd9;
  localparam logic [3:0] CMD_ILW  = 4'd10;
  localparam logic [3:0] CMD_ISW  = 4'd11;
  localparam logic [3:0] CMD_ILWR = 4'd12;
  localparam logic [3:0] CMD_ISWR = 4'd13;
  localparam logic [3:0] CMD_LOI  = 4'd14;
  localparam logic [3:0] CMD_MFP  = 4'd15;

endpackage

>>> src/vute_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vute_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module vute_ram #(
  parameter int WIDTH = vute_pkg::QWORD_W,
  parameter int DEPTH = vute_pkg::VREGS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/vector_unit_transfer_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_unit_transfer_execute
// Executes one vector-unit transfer instruction per beat over a vector
// register RAM, an integer register file, an immediate register and a
// qword data memory RAM.
//
// channel | ports                        | handshake
// in      | in_* fields                  | accepted when start && !busy
// out     | out_* fields                 | out_valid, one cycle, no stall
//
// Each beat steps through the busy states src read, dst read and address
// multiply, modulo reduce and memory read, and execute and write back, after
// the idle state in which start is taken; the single RAM read ports set this.
// Result appears the cycle after the execute step.
// After reset the data memory is cleared, one qword a cycle, with busy high
// until every qword is cleared.
// ----------------------------------------------------------------------------
module vector_unit_transfer_execute #(
  parameter int MEM_QWORDS = vute_pkg::MEM_QWORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_command,
  input  logic [4:0]  in_src_vector_reg,
  input  logic [4:0]  in_dst_vector_reg,
  input  logic [3:0]  in_src_int_reg,
  input  logic [3:0]  in_tgt_int_reg,
  input  logic [3:0]  in_lane_mask,
  input  logic [1:0]  in_lane_select,
  input  logic signed [10:0] in_offset,
  input  logic [31:0] in_immediate_word,
  input  logic [31:0] in_p_value,
  output logic        out_valid,
  output logic        out_vector_written,
  output logic [4:0]  out_vector_index,
  output logic [31:0] out_lane_x,
  output logic [31:0] out_lane_y,
  output logic [31:0] out_lane_z,
  output logic [31:0] out_lane_w,
  output logic        out_int_written,
  output logic [3:0]  out_int_index,
  output logic [15:0] out_int_value,
  output logic        out_mem_written,
  output logic [9:0]  out_mem_address,
  output logic [31:0] out_imm_value
);

  localparam int AW = $clog2(MEM_QWORDS);
  localparam int QW = vute_pkg::QWORD_W;
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / MEM_QWORDS);
  localparam logic [31:0] MODV  = 32'(MEM_QWORDS);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_A    = 3'd2;
  localparam logic [2:0] S_B    = 3'd3;
  localparam logic [2:0] S_M    = 3'd4;
  localparam logic [2:0] S_C    = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;

  logic [3:0]  cmd_r;
  logic [4:0]  fs_r, ft_r;
  logic [3:0]  is_r, it_r, mask_r;
  logic [1:0]  sel_r;
  logic [10:0] off_r;
  logic [31:0] immw_r, pv_r;

  logic [15:0] intf_r [16];
  logic [vute_pkg::VREGS-1:0] vvld_r;
  logic        rd_vld_r;
  logic [31:0] imm_r;

  logic [15:0] base_r, idata_r, addr16_r;
  logic [48:0] prod_r;
  logic [QW-1:0] src_r, dst_r;
  logic [AW-1:0] a_r;
  logic [AW-1:0] a_nxt;

  // vector RAM
  logic          vec_we;
  logic [QW-1:0] vec_wdata, vec_rdata;
  logic [4:0]    vec_raddr;

  // data RAM
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [QW-1:0] mem_wdata, mem_rdata;

  vute_ram #(.WIDTH(QW), .DEPTH(vute_pkg::VREGS)) u_vram (
    .clk(clk), .we(vec_we), .waddr(ft_r), .wdata(vec_wdata),
    .raddr(vec_raddr), .rdata(vec_rdata)
  );

  vute_ram #(.WIDTH(QW), .DEPTH(MEM_QWORDS)) u_dram (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(a_nxt), .rdata(mem_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign vec_raddr = (state_r == S_A) ? fs_r : ft_r;

  logic       st_base_it;
  logic [3:0] base_idx;
  assign st_base_it = (cmd_r == vute_pkg::CMD_SQ) || (cmd_r == vute_pkg::CMD_SQD) ||
                      (cmd_r == vute_pkg::CMD_SQI);
  assign base_idx   = st_base_it ? it_r : is_r;

  logic [15:0] addr16;
  always_comb begin
    case (cmd_r)
      vute_pkg::CMD_LQ, vute_pkg::CMD_SQ, vute_pkg::CMD_ILW, vute_pkg::CMD_ISW:
        addr16 = base_r + {{5{off_r[10]}}, off_r};
      vute_pkg::CMD_LQD, vute_pkg::CMD_SQD: addr16 = base_r - 16'd1;
      default: addr16 = base_r;
    endcase
  end

  // modulo by constant: reciprocal estimate, one correction
  logic [15:0] q_est;
  logic [31:0] rem0;
  assign q_est = prod_r[47:32];
  assign rem0  = {16'd0, addr16_r} - (32'(q_est) * MODV);
  assign a_nxt = (rem0 >= MODV) ? AW'(rem0 - MODV) : AW'(rem0);

  // execute
  logic [QW-1:0] mrg_src, new_vec, new_mem;
  logic          do_vec, do_mem, do_int, vw, mw, rep_addr;
  logic [3:0]    int_idx;
  logic [15:0]   int_val;
  logic [1:0]    hi_lane;

  always_comb begin
    if (mask_r[3]) hi_lane = 2'd3;
    else if (mask_r[2]) hi_lane = 2'd2;
    else if (mask_r[1]) hi_lane = 2'd1;
    else hi_lane = 2'd0;
  end

  always_comb begin
    mrg_src  = src_r;
    do_vec   = 1'b0;
    do_mem   = 1'b0;
    do_int   = 1'b0;
    vw       = 1'b0;
    mw       = 1'b0;
    rep_addr = 1'b0;
    int_idx  = it_r;
    int_val  = 16'd0;
    new_vec  = dst_r;
    new_mem  = mem_rdata;
    case (cmd_r)
      vute_pkg::CMD_MOVE: begin
        do_vec = 1'b1; vw = |mask_r;
      end
      vute_pkg::CMD_MFIR: begin
        mrg_src = {4{16'd0, base_r}}; do_vec = 1'b1; vw = |mask_r;
      end
      vute_pkg::CMD_MFP: begin
        mrg_src = {4{pv_r}}; do_vec = 1'b1; vw = |mask_r;
      end
      vute_pkg::CMD_MTIR: begin
        do_int = 1'b1; int_val = src_r[32*sel_r +: 16];
      end
      vute_pkg::CMD_MR32: begin
        do_vec = 1'b1; vw = 1'b1;
      end
      vute_pkg::CMD_LQ, vute_pkg::CMD_LQD, vute_pkg::CMD_LQI: begin
        mrg_src = mem_rdata; do_vec = 1'b1; vw = |mask_r; rep_addr = 1'b1;
        int_idx = is_r;
        do_int  = (cmd_r != vute_pkg::CMD_LQ);
        int_val = (cmd_r == vute_pkg::CMD_LQD) ? base_r - 16'd1 : base_r + 16'd1;
      end
      vute_pkg::CMD_SQ, vute_pkg::CMD_SQD, vute_pkg::CMD_SQI: begin
        do_mem = 1'b1; mw = |mask_r; rep_addr = 1'b1;
        int_idx = it_r;
        do_int  = (cmd_r != vute_pkg::CMD_SQ);
        int_val = (cmd_r == vute_pkg::CMD_SQD) ? base_r - 16'd1 : base_r + 16'd1;
      end
      vute_pkg::CMD_ILW, vute_pkg::CMD_ILWR: begin
        rep_addr = 1'b1; do_int = |mask_r;
        int_val  = mem_rdata[32*hi_lane +: 16];
      end
      vute_pkg::CMD_ISW, vute_pkg::CMD_ISWR: begin
        mrg_src = {4{16'd0, idata_r}}; do_mem = 1'b1; mw = |mask_r; rep_addr = 1'b1;
      end
      default: ;
    endcase
    for (int k = 0; k < 4; k++) begin
      if (mask_r[k]) begin
        new_vec[32*k +: 32] = mrg_src[32*k +: 32];
        new_mem[32*k +: 32] = mrg_src[32*k +: 32];
      end
    end
    if (cmd_r == vute_pkg::CMD_MR32) begin
      new_vec = {src_r[95:64], src_r[63:32], src_r[31:0], src_r[127:96]};
    end
  end

  assign vec_we    = (state_r == S_C) && do_vec;
  assign vec_wdata = new_vec;
  assign mem_we    = (state_r == S_CLR) || ((state_r == S_C) && do_mem);
  assign mem_waddr = (state_r == S_CLR) ? clr_cnt_r : a_r;
  assign mem_wdata = (state_r == S_CLR) ? '0 : new_mem;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (clr_cnt_r == AW'(MEM_QWORDS - 1)) state_nxt = S_IDLE;
      S_IDLE: if (start) state_nxt = S_A;
      S_A:    state_nxt = S_B;
      S_B:    state_nxt = S_M;
      S_M:    state_nxt = S_C;
      S_C:    state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [15:0] a_ext;
  assign a_ext = 16'(a_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_cnt_r <= '0;
      vvld_r    <= '0;
      imm_r     <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 16; i++) intf_r[i] <= '0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= (state_r == S_C);
      if (state_r == S_CLR) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (vec_we) vvld_r[ft_r] <= 1'b1;
      if ((state_r == S_C) && do_int) intf_r[int_idx] <= int_val;
      if ((state_r == S_C) && (cmd_r == vute_pkg::CMD_LOI)) imm_r <= immw_r;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && start) begin
      cmd_r  <= in_command;
      fs_r   <= in_src_vector_reg;
      ft_r   <= in_dst_vector_reg;
      is_r   <= in_src_int_reg;
      it_r   <= in_tgt_int_reg;
      mask_r <= in_lane_mask;
      sel_r  <= in_lane_select;
      off_r  <= in_offset;
      immw_r <= in_immediate_word;
      pv_r   <= in_p_value;
    end
    rd_vld_r <= vvld_r[vec_raddr];
    if (state_r == S_A) begin
      base_r <= intf_r[base_idx];
    end
    if (state_r == S_B) begin
      src_r    <= rd_vld_r ? vec_rdata : '0;
      idata_r  <= intf_r[it_r];
      addr16_r <= addr16;
      prod_r   <= 49'(addr16) * 49'(RECIP);
    end
    if (state_r == S_M) begin
      dst_r <= rd_vld_r ? vec_rdata : '0;
      a_r   <= a_nxt;
    end
    if (state_r == S_C) begin
      out_vector_written <= vw;
      out_vector_index   <= do_vec ? ft_r : 5'd0;
      out_lane_x         <= do_vec ? new_vec[31:0]   : (do_mem ? new_mem[31:0]   : 32'd0);
      out_lane_y         <= do_vec ? new_vec[63:32]  : (do_mem ? new_mem[63:32]  : 32'd0);
      out_lane_z         <= do_vec ? new_vec[95:64]  : (do_mem ? new_mem[95:64]  : 32'd0);
      out_lane_w         <= do_vec ? new_vec[127:96] : (do_mem ? new_mem[127:96] : 32'd0);
      out_int_written    <= do_int;
      out_int_index      <= do_int ? int_idx : 4'd0;
      out_int_value      <= do_int ? int_val : 16'd0;
      out_mem_written    <= mw;
      out_mem_address    <= rep_addr ? a_ext[9:0] : 10'd0;
      out_imm_value      <= (cmd_r == vute_pkg::CMD_LOI) ? immw_r : imm_r;
    end
  end

  a_out_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_C))
    else $error("result strobe without execute step");

  a_exec_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_C) |=> (state_r == S_IDLE) && out_valid)
    else $error("execute step did not retire");

  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_A))
    else $error("accepted beat did not start sequence");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !vec_we && !mem_we)
    else $error("RAM write while idle");

endmodule

>>> test/vute_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vute_checker
// Watches the command and result channels of the transfer execute block,
// keeps a shadow of its register files and data memory, and compares each
// result beat, all fields together, with the predicted one.
// ----------------------------------------------------------------------------
module vute_checker #(
  parameter int MEM_QWORDS = vute_pkg::MEM_QWORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [3:0]         in_command,
  input  logic [4:0]         in_src_vector_reg,
  input  logic [4:0]         in_dst_vector_reg,
  input  logic [3:0]         in_src_int_reg,
  input  logic [3:0]         in_tgt_int_reg,
  input  logic [3:0]         in_lane_mask,
  input  logic [1:0]         in_lane_select,
  input  logic signed [10:0] in_offset,
  input  logic [31:0]        in_immediate_word,
  input  logic [31:0]        in_p_value,
  input  logic               out_valid,
  input  logic               out_vector_written,
  input  logic [4:0]         out_vector_index,
  input  logic [31:0]        out_lane_x,
  input  logic [31:0]        out_lane_y,
  input  logic [31:0]        out_lane_z,
  input  logic [31:0]        out_lane_w,
  input  logic               out_int_written,
  input  logic [3:0]         out_int_index,
  input  logic [15:0]        out_int_value,
  input  logic               out_mem_written,
  input  logic [9:0]         out_mem_address,
  input  logic [31:0]        out_imm_value,
  output int                 errors,
  output int                 pending,
  output int                 beats_checked
);

  typedef struct packed {
    logic        vw;
    logic [4:0]  vidx;
    logic [31:0] lx, ly, lz, lw;
    logic        iw;
    logic [3:0]  iidx;
    logic [15:0] ival;
    logic        mw;
    logic [9:0]  maddr;
    logic [31:0] imm;
  } xfer_result_t;

  logic [31:0] vregs [32][4];
  logic [15:0] iregs [16];
  logic [31:0] imm_shadow;
  logic [31:0] qmem [MEM_QWORDS][4];
  xfer_result_t expected_results[$];

  function automatic int unsigned wrap_addr(logic [15:0] base, logic signed [10:0] off);
    logic [15:0] sum;
    sum = base + {{5{off[10]}}, off};
    return int'(sum) % MEM_QWORDS;
  endfunction

  task automatic execute_command();
    logic [31:0] src [4];
    logic [31:0] v1;
    xfer_result_t r;
    int unsigned a;
    int lane;
    bit vrep, mrep;
    logic [3:0] is_, it_, m;
    logic [4:0] ft;
    r = '0; a = 0; vrep = 0; mrep = 0; lane = -1;
    is_ = in_src_int_reg; it_ = in_tgt_int_reg; m = in_lane_mask; ft = in_dst_vector_reg;
    for (int k = 0; k < 4; k++) src[k] = vregs[in_src_vector_reg][k];
    case (in_command)
      vute_pkg::CMD_MOVE, vute_pkg::CMD_MFIR, vute_pkg::CMD_MFP: begin
        v1 = (in_command == vute_pkg::CMD_MFIR) ? {16'h0, iregs[is_]} : in_p_value;
        for (int k = 0; k < 4; k++)
          if (m[k]) vregs[ft][k] = (in_command == vute_pkg::CMD_MOVE) ? src[k] : v1;
        r.vw = (m != 0); r.vidx = ft; vrep = 1;
      end
      vute_pkg::CMD_MTIR: begin
        iregs[it_] = src[in_lane_select][15:0];
        r.iw = 1; r.iidx = it_; r.ival = iregs[it_];
      end
      vute_pkg::CMD_MR32: begin
        vregs[ft][0] = src[3]; vregs[ft][1] = src[0];
        vregs[ft][2] = src[1]; vregs[ft][3] = src[2];
        r.vw = 1; r.vidx = ft; vrep = 1;
      end
      vute_pkg::CMD_LQ, vute_pkg::CMD_LQD, vute_pkg::CMD_LQI: begin
        if (in_command == vute_pkg::CMD_LQ) a = wrap_addr(iregs[is_], in_offset);
        else if (in_command == vute_pkg::CMD_LQD) begin
          iregs[is_] = iregs[is_] - 16'd1;
          a = int'(iregs[is_]) % MEM_QWORDS;
          r.iw = 1; r.iidx = is_; r.ival = iregs[is_];
        end else a = int'(iregs[is_]) % MEM_QWORDS;
        for (int k = 0; k < 4; k++) if (m[k]) vregs[ft][k] = qmem[a][k];
        if (in_command == vute_pkg::CMD_LQI) begin
          iregs[is_] = iregs[is_] + 16'd1;
          r.iw = 1; r.iidx = is_; r.ival = iregs[is_];
        end
        r.vw = (m != 0); r.vidx = ft; vrep = 1; r.maddr = a[9:0];
      end
      vute_pkg::CMD_SQ, vute_pkg::CMD_SQD, vute_pkg::CMD_SQI: begin
        if (in_command == vute_pkg::CMD_SQ) a = wrap_addr(iregs[it_], in_offset);
        else if (in_command == vute_pkg::CMD_SQD) begin
          iregs[it_] = iregs[it_] - 16'd1;
          a = int'(iregs[it_]) % MEM_QWORDS;
          r.iw = 1; r.iidx = it_; r.ival = iregs[it_];
        end else a = int'(iregs[it_]) % MEM_QWORDS;
        for (int k = 0; k < 4; k++) if (m[k]) qmem[a][k] = src[k];
        if (in_command == vute_pkg::CMD_SQI) begin
          iregs[it_] = iregs[it_] + 16'd1;
          r.iw = 1; r.iidx = it_; r.ival = iregs[it_];
        end
        r.mw = (m != 0); mrep = 1; r.maddr = a[9:0];
      end
      vute_pkg::CMD_ILW, vute_pkg::CMD_ILWR: begin
        a = (in_command == vute_pkg::CMD_ILW) ? wrap_addr(iregs[is_], in_offset)
                                              : int'(iregs[is_]) % MEM_QWORDS;
        for (int k = 0; k < 4; k++) if (m[k]) lane = k;
        if (lane >= 0) begin
          iregs[it_] = qmem[a][lane][15:0];
          r.iw = 1; r.iidx = it_; r.ival = iregs[it_];
        end
        r.maddr = a[9:0];
      end
      vute_pkg::CMD_ISW, vute_pkg::CMD_ISWR: begin
        a = (in_command == vute_pkg::CMD_ISW) ? wrap_addr(iregs[is_], in_offset)
                                              : int'(iregs[is_]) % MEM_QWORDS;
        for (int k = 0; k < 4; k++) if (m[k]) qmem[a][k] = {16'h0, iregs[it_]};
        r.mw = (m != 0); mrep = 1; r.maddr = a[9:0];
      end
      default: imm_shadow = in_immediate_word;
    endcase
    if (vrep) begin
      r.lx = vregs[ft][0]; r.ly = vregs[ft][1]; r.lz = vregs[ft][2]; r.lw = vregs[ft][3];
    end else if (mrep) begin
      r.lx = qmem[a][0]; r.ly = qmem[a][1]; r.lz = qmem[a][2]; r.lw = qmem[a][3];
    end
    r.imm = imm_shadow;
    expected_results.push_back(r);
  endtask

  always @(posedge clk) begin
    xfer_result_t got, exp_r;
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) for (int k = 0; k < 4; k++) vregs[i][k] = '0;
      for (int i = 0; i < 16; i++) iregs[i] = '0;
      for (int i = 0; i < MEM_QWORDS; i++) for (int k = 0; k < 4; k++) qmem[i][k] = '0;
      imm_shadow = '0;
      expected_results.delete();
      errors = 0;
      beats_checked = 0;
    end else begin
      if (out_valid) begin
        got = '{out_vector_written, out_vector_index, out_lane_x, out_lane_y, out_lane_z,
                out_lane_w, out_int_written, out_int_index, out_int_value,
                out_mem_written, out_mem_address, out_imm_value};
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat: %h", got);
        end else begin
          exp_r = expected_results.pop_front();
          beats_checked++;
          if (got !== exp_r) begin
            errors++;
            if (errors <= 10)
              $display("mismatch beat %0d\n  exp %h\n  got %h", beats_checked, exp_r, got);
          end
        end
      end
      if (start && !busy) execute_command();
    end
    pending = expected_results.size();
  end

endmodule

>>> test/tb_vector_unit_transfer_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_unit_transfer_execute
// Drives directed and random transfer commands into the block under varying
// sender idle rates; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_vector_unit_transfer_execute;

  localparam int MEMQ = 1024;
  localparam int LIMIT = 400000;

  logic clk = 0, rst_n = 0, start = 0, busy;
  logic [3:0] in_command = 0, in_src_int_reg = 0, in_tgt_int_reg = 0, in_lane_mask = 0;
  logic [4:0] in_src_vector_reg = 0, in_dst_vector_reg = 0;
  logic [1:0] in_lane_select = 0;
  logic signed [10:0] in_offset = 0;
  logic [31:0] in_immediate_word = 0, in_p_value = 0;
  logic out_valid, out_vector_written, out_int_written, out_mem_written;
  logic [4:0] out_vector_index;
  logic [31:0] out_lane_x, out_lane_y, out_lane_z, out_lane_w, out_imm_value;
  logic [3:0] out_int_index;
  logic [15:0] out_int_value;
  logic [9:0] out_mem_address;
  int errors, pending, beats_checked, cycles, sent;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_vector_unit_transfer_execute NOT OK");
      $finish;
    end
  end

  vector_unit_transfer_execute #(.MEM_QWORDS(MEMQ)) DUT (.*);
  vute_checker #(.MEM_QWORDS(MEMQ)) u_checker (.*);

  task automatic send(logic [3:0] cmd, logic [4:0] fs, logic [4:0] ft, logic [3:0] is_,
                      logic [3:0] it_, logic [3:0] m, logic [1:0] sel,
                      logic [10:0] off, logic [31:0] immw, logic [31:0] pv);
    in_command <= cmd; in_src_vector_reg <= fs; in_dst_vector_reg <= ft;
    in_src_int_reg <= is_; in_tgt_int_reg <= it_; in_lane_mask <= m;
    in_lane_select <= sel; in_offset <= off; in_immediate_word <= immw;
    in_p_value <= pv; start <= 1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_random(int idle_pct);
    logic [3:0] cmd, r4;
    cmd = 4'($urandom_range(0, 15));
    r4 = 4'($urandom_range(0, 3));
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    // small register indexes keep loads and stores hitting the same qwords
    send(cmd, r4[1] ? 5'($urandom_range(0, 3)) : 5'($urandom()),
         r4[0] ? 5'($urandom_range(0, 3)) : 5'($urandom()),
         4'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
         ($urandom_range(9) == 0) ? 4'h0 : 4'($urandom()), 2'($urandom()),
         ($urandom_range(3) == 0) ? 11'($urandom()) : 11'($urandom_range(0, 7) - 4),
         $urandom(), ($urandom_range(5) == 0) ? 32'hFFFF_FFFF : $urandom());
  endtask

  initial begin
    int idle_pct;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    // directed: extremes, every command, empty mask, multi-lane ILW, wraps
    send(vute_pkg::CMD_MFP, 0, 31, 0, 0, 4'hF, 0, 0, 0, 32'hFFFF_FFFF);
    send(vute_pkg::CMD_LOI, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);
    send(vute_pkg::CMD_MTIR, 31, 0, 0, 15, 0, 3, 0, 0, 0);
    send(vute_pkg::CMD_MOVE, 31, 1, 0, 0, 4'h5, 0, 0, 0, 0);
    send(vute_pkg::CMD_MFIR, 0, 2, 15, 0, 4'hA, 0, 0, 0, 0);
    send(vute_pkg::CMD_MR32, 1, 1, 0, 0, 0, 0, 0, 0, 0);
    send(vute_pkg::CMD_SQ, 31, 0, 0, 15, 4'hF, 0, 11'sh400, 0, 0);
    send(vute_pkg::CMD_SQD, 1, 0, 0, 3, 4'hF, 0, 0, 0, 0);
    send(vute_pkg::CMD_SQI, 1, 0, 0, 3, 4'h0, 0, 0, 0, 0);
    send(vute_pkg::CMD_LQ, 0, 5, 15, 0, 4'hF, 0, 11'sh3FF, 0, 0);
    send(vute_pkg::CMD_LQD, 0, 6, 3, 0, 4'hF, 0, 0, 0, 0);
    send(vute_pkg::CMD_LQI, 0, 7, 3, 0, 4'h3, 0, 0, 0, 0);
    send(vute_pkg::CMD_LQ, 0, 8, 15, 0, 4'h0, 0, 11'sh400, 0, 0);
    send(vute_pkg::CMD_ILW, 0, 0, 3, 9, 4'h7, 0, 11'sh7FF, 0, 0);
    send(vute_pkg::CMD_ILWR, 0, 0, 3, 10, 4'hF, 0, 0, 0, 0);
    send(vute_pkg::CMD_ILWR, 0, 0, 3, 11, 4'h0, 0, 0, 0, 0);
    send(vute_pkg::CMD_ISW, 0, 0, 3, 15, 4'h9, 0, 11'sh001, 0, 0);
    send(vute_pkg::CMD_ISWR, 0, 0, 3, 15, 4'hF, 0, 0, 0, 0);
    send(vute_pkg::CMD_MOVE, 4, 4, 0, 0, 4'h0, 0, 0, 0, 0);
    send(vute_pkg::CMD_MTIR, 2, 0, 0, 0, 0, 0, 0, 0, 0);
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 16 : (ph == 1) ? 53 : 0;
      repeat (400) send_random(idle_pct);
    end
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("%0d commands sent, %0d result beats checked over three idle mixes",
             sent, beats_checked);
    if (errors == 0 && pending == 0) $display("tb_vector_unit_transfer_execute OK");
    else $display("tb_vector_unit_transfer_execute NOT OK");
    $finish;
  end

endmodule

>>> sim.f
src/vute_pkg.sv
src/vute_ram.sv
src/vector_unit_transfer_execute.sv
test/vute_checker.sv
test/tb_vector_unit_transfer_execute.sv
